// ===== sv/am_envelope_dc_block_unit_macros.svh =====
// Assertion macros for the envelope detector checker.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef AM_ENVELOPE_DC_BLOCK_UNIT_MACROS_SVH
`define AM_ENVELOPE_DC_BLOCK_UNIT_MACROS_SVH

// Same-cycle implication.
`define AMENV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("am_envelope_dc_block_unit check failed");

// Next-cycle implication.
`define AMENV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("am_envelope_dc_block_unit check failed");

`endif

// ===== sv/amenv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package amenv_pkg;

    // Filter accumulator (Q.frac) width and its split for the partial products.
    localparam int unsigned ACC_BITS  = 46;
    localparam int unsigned ACC_HALF  = ACC_BITS / 2;
    localparam int unsigned ACC_HI_W  = ACC_BITS - ACC_HALF;

    // Pole coefficient.
    localparam int unsigned ALPHA_W     = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd65529;
    localparam logic ENABLE_RESET = 1'b1;

    // Configuration port.
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DC_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_ROOT,
        S_MUL_LO,
        S_MUL_HI,
        S_FILT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic sq_re;
        logic sq_im;
        logic root_step;
        logic mul_lo;
        logic mul_hi;
        logic filt;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== sv/amenv_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amenv_ctrl #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  logic               i_dc_enable,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output amenv_pkg::t_dp_cmd o_cmd
);
    import amenv_pkg::*;

    localparam int unsigned CNT_W = (SAMPLE_WIDTH > 1) ? $clog2(SAMPLE_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SQ_RE;
                end
            end
            S_SQ_RE: begin
                o_cmd.sq_re = 1'b1;
                n_state     = S_SQ_IM;
            end
            S_SQ_IM: begin
                o_cmd.sq_im = 1'b1;
                n_cnt       = '0;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = i_dc_enable ? S_MUL_LO : S_FINISH;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_FILT;
            end
            S_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.finish || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/amenv_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amenv_dp #(
    parameter int unsigned SAMPLE_WIDTH    = 16,
    parameter int unsigned ALPHA_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  amenv_pkg::t_dp_cmd                i_cmd,
    input  logic                              i_dc_enable,
    input  logic [amenv_pkg::ALPHA_W-1:0]     i_pole_coef,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_in_im,
    output logic signed [SAMPLE_WIDTH-1:0]    o_audio_out
);
    import amenv_pkg::*;

    localparam int unsigned SW     = SAMPLE_WIDTH;
    localparam int unsigned SQ_W   = 2 * SW;
    localparam int unsigned MUL_W  = (SW > ACC_HALF) ? SW : ACC_HALF;
    localparam int unsigned PLO_W  = ALPHA_W + ACC_HALF;
    localparam int unsigned PHI_W  = ALPHA_W + ACC_HI_W;
    localparam int unsigned PROD_W = ALPHA_W + ACC_BITS;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned DIFF_W = ACC_BITS + 1;

    logic [SW-1:0]         r_abs_re, r_abs_im;
    logic [SQ_W-1:0]       r_rad;
    logic [SW:0]           r_rem;
    logic [SW-1:0]         r_root;
    logic [PLO_W-1:0]      r_plo;
    logic [PROD_W-1:0]     r_prod;
    logic [ACC_BITS-1:0]   r_w;
    logic [ACC_BITS-1:0]   r_prev;
    logic signed [SW-1:0]  r_out;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic [SW+2:0]         rem_sh, trial;
    logic                  root_bit;
    logic [SUM_W-1:0]      w_sum;
    logic [ACC_BITS-1:0]   w_sat;
    logic signed [DIFF_W-1:0] diff, diff_sh;
    logic                  in_range;
    logic signed [SW-1:0]  filt_audio, audio;

    // Shared multiplier: squares first, then the two coefficient partial products.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.sq_re) begin
            mul_a = MUL_W'(r_abs_re);
            mul_b = MUL_W'(r_abs_re);
        end else if (i_cmd.sq_im) begin
            mul_a = MUL_W'(r_abs_im);
            mul_b = MUL_W'(r_abs_im);
        end else if (i_cmd.mul_lo) begin
            mul_a = MUL_W'(r_prev[ACC_HALF-1:0]);
            mul_b = MUL_W'(i_pole_coef);
        end else if (i_cmd.mul_hi) begin
            mul_a = MUL_W'(r_prev[ACC_BITS-1:ACC_HALF]);
            mul_b = MUL_W'(i_pole_coef);
        end
    end
    assign mul_p = mul_a * mul_b;

    // One root bit per step.
    assign rem_sh   = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign root_bit = (rem_sh >= trial);

    // w = alpha*prev/2^F + mag*2^F, saturated to the accumulator range.
    assign w_sum = SUM_W'(r_prod >> ALPHA_FRAC_BITS) + (SUM_W'(r_root) << ALPHA_FRAC_BITS);
    assign w_sat = (|w_sum[SUM_W-1:ACC_BITS]) ? {ACC_BITS{1'b1}} : w_sum[ACC_BITS-1:0];

    // (w - prev) / 2^(F+1), floor, then saturate.
    assign diff     = $signed({1'b0, r_w}) - $signed({1'b0, r_prev});
    assign diff_sh  = diff >>> (ALPHA_FRAC_BITS + 1);
    assign in_range = (&diff_sh[DIFF_W-1:SW-1]) || !(|diff_sh[DIFF_W-1:SW-1]);

    always_comb begin
        if (in_range) begin
            filt_audio = diff_sh[SW-1:0];
        end else if (diff_sh[DIFF_W-1]) begin
            filt_audio = {1'b1, {(SW-1){1'b0}}};
        end else begin
            filt_audio = {1'b0, {(SW-1){1'b1}}};
        end
        audio = i_dc_enable ? filt_audio : $signed({1'b0, r_root[SW-1:1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_abs_re <= i_in_re[SW-1] ? (~i_in_re + 1'b1) : i_in_re;
            r_abs_im <= i_in_im[SW-1] ? (~i_in_im + 1'b1) : i_in_im;
        end
        if (i_cmd.sq_re) begin
            r_rad <= mul_p[SQ_W-1:0];
        end
        if (i_cmd.sq_im) begin
            r_rad  <= r_rad + mul_p[SQ_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= root_bit ? (SW+1)'(rem_sh - trial) : rem_sh[SW:0];
            r_root <= {r_root[SW-2:0], root_bit};
        end
        if (i_cmd.mul_lo) begin
            r_plo <= mul_p[PLO_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_prod <= {mul_p[PHI_W-1:0], {ACC_HALF{1'b0}}} + PROD_W'(r_plo);
        end
        if (i_cmd.filt) begin
            r_w <= w_sat;
        end
        if (i_cmd.finish) begin
            r_out <= audio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.finish && i_dc_enable) begin
            r_prev <= r_w;
        end
    end

    assign o_audio_out = r_out;

endmodule

`default_nettype wire

// ===== sv/am_envelope_dc_block_unit.sv =====
// Channel   Direction  Handshake                Payload
// in        sink       i_in_valid / o_in_stall  i_in_re, i_in_im (signed SAMPLE_WIDTH)
// out       source     o_out_valid / i_out_stall o_audio_out (signed SAMPLE_WIDTH)
// cfg       APB slave  psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// One sample at a time. The square root produces one bit per cycle; the shared
// multiplier forms the two squares and then the two partial products of the
// 16 x 46 coefficient product. Plain mode skips the coefficient product and filter.
// Reset (synchronous, active low) clears the controller, the accumulator and the
// registers to enable = 1, alpha = 65529.
// A stalled result stays in the output register; the next sample is accepted
// while it waits, and the controller holds its last step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module am_envelope_dc_block_unit #(
    parameter int unsigned SAMPLE_WIDTH    = 16,
    parameter int unsigned ALPHA_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input sample channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_in_im,
    // audio channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       o_audio_out,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [amenv_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [amenv_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [amenv_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import amenv_pkg::*;

    logic                 r_dc_enable;
    logic [ALPHA_W-1:0]   r_pole_coef;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    t_dp_cmd              cmd;

    // Registers sit at byte address 4*i; drop the byte offset.
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_enable <= ENABLE_RESET;
            r_pole_coef <= ALPHA_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DC_ENABLE: r_dc_enable <= pwdata[0];
                REG_POLE_COEF: r_pole_coef <= pwdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DC_ENABLE: prdata = CFG_DATA_W'(r_dc_enable);
            REG_POLE_COEF: prdata = CFG_DATA_W'(r_pole_coef);
            default:       prdata = '0;
        endcase
    end

    // Sequencer: one step of the datapath per state.
    amenv_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_dc_enable (r_dc_enable),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Magnitude, DC blocker accumulator and output register.
    amenv_dp #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_dc_enable (r_dc_enable),
        .i_pole_coef (r_pole_coef),
        .i_in_re     (i_in_re),
        .i_in_im     (i_in_im),
        .o_audio_out (o_audio_out)
    );

endmodule

`default_nettype wire

// ===== sv/amenv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "am_envelope_dc_block_unit_macros.svh"

module amenv_checker #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [SAMPLE_WIDTH-1:0] o_audio_out
);

    // A stalled result stays valid and unchanged.
    `AMENV_ASSERT_NEXT(a_out_valid_hold, o_out_valid && i_out_stall, o_out_valid)
    `AMENV_ASSERT_NEXT(a_out_data_hold, o_out_valid && i_out_stall, $stable(o_audio_out))

    // One sample at a time: a transfer in closes the input.
    `AMENV_ASSERT_NEXT(a_busy_after_in, i_in_valid && !o_in_stall, o_in_stall)

    // The input reopens only as a result lands in the output register.
    `AMENV_ASSERT_IMP(a_reopen_with_result, $fell(o_in_stall) && $past(i_rst_n), o_out_valid)

endmodule

bind am_envelope_dc_block_unit amenv_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_amenv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_audio_out (o_audio_out)
);

`default_nettype wire

// ===== test/tb_am_envelope_dc_block_unit.sv =====
`timescale 1ns / 1ps

module tb_am_envelope_dc_block_unit;
    import amenv_pkg::*;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned ACC_W      = ACC_BITS;
    localparam logic [63:0] ACC_MAX    = (64'd1 << ACC_W) - 64'd1;
    localparam longint      AUDIO_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint      AUDIO_MIN  = -AUDIO_MAX - 1;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = AUDIO_MAX[SAMPLE_W-1:0];
    localparam logic signed [SAMPLE_W-1:0] S_MIN = AUDIO_MIN[SAMPLE_W-1:0];
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_SAMPLES = 250;
    localparam int unsigned CHUNK_SAMPLES = 50;

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_iq_sample;

    // Clock, reset and every block input start at known values.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_W-1:0]    i_in_re     = '0;
    logic signed [SAMPLE_W-1:0]    i_in_im     = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]    o_audio_out;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0]         paddr       = '0;
    logic [CFG_DATA_W-1:0]         pwdata      = '0;
    logic [CFG_DATA_W-1:0]         prdata;
    logic                          pready;

    am_envelope_dc_block_unit #(
        .SAMPLE_WIDTH    (SAMPLE_W),
        .ALPHA_FRAC_BITS (FRAC_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_re     (i_in_re),
        .i_in_im     (i_in_im),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_audio_out (o_audio_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Samples waiting to be driven and audio values waiting to come out.
    t_iq_sample                    sample_q[$];
    logic signed [SAMPLE_W-1:0]    audio_q[$];

    // Shadow of the block's registers and filter accumulator.
    logic                          dc_enable = ENABLE_RESET;
    logic [ALPHA_W-1:0]            pole_coef = ALPHA_RESET;
    logic [ACC_W-1:0]              dc_acc    = '0;

    // Percent of cycles on which each side holds off.
    int unsigned                   in_idle_pct  = 0;
    int unsigned                   out_stall_pct = 0;

    logic                          in_taken = 1'b0;
    int unsigned                   err_count   = 0;
    int unsigned                   in_count    = 0;
    int unsigned                   out_count   = 0;
    int unsigned                   clamp_count = 0;
    int unsigned                   cycle_count = 0;

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Envelope plus DC blocker: magnitude by bitwise square root, then either half
    // the magnitude or the one-pole high-pass. Advance the accumulator only in
    // filtered mode.
    function automatic logic signed [SAMPLE_W-1:0] envelope_predict(
        input logic signed [SAMPLE_W-1:0] re,
        input logic signed [SAMPLE_W-1:0] im
    );
        longint             power;
        longint             trial_sq;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] trial;
        logic [63:0]        decayed;
        logic [63:0]        w;
        longint             diff;
        longint             audio;
        int                 b;
        power = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        mag = '0;
        for (b = SAMPLE_W - 1; b >= 0; b--) begin
            trial = mag | (SAMPLE_W'(1) << b);
            trial_sq = trial;
            trial_sq = trial_sq * trial_sq;
            if (trial_sq <= power)
                mag = trial;
        end
        if (dc_enable) begin
            decayed = (64'(pole_coef) * 64'(dc_acc)) >> FRAC_W;
            w = decayed + (64'(mag) << FRAC_W);
            if (w > ACC_MAX) begin
                // the accumulator never wraps, it pins at full scale
                w = ACC_MAX;
                clamp_count++;
            end
            diff = longint'(w) - longint'(64'(dc_acc));
            audio = diff >>> (FRAC_W + 1);
            dc_acc = w[ACC_W-1:0];
        end else begin
            audio = mag >> 1;
        end
        if (audio > AUDIO_MAX)
            audio = AUDIO_MAX;
        else if (audio < AUDIO_MIN)
            audio = AUDIO_MIN;
        return audio[SAMPLE_W-1:0];
    endfunction

    task automatic note_error(input string what, input longint want, input longint got);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Driver: change inputs on the falling edge. Hold a sample until it transfers,
    // then present the next one or drop valid.
    always @(negedge i_clk) begin : driver
        t_iq_sample next_s;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
            if (!i_in_valid || in_taken) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    next_s = sample_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_re    <= next_s.re;
                    i_in_im    <= next_s.im;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample both channels on the rising edge. Check the audio transfer
    // against the oldest prediction first, then predict for a new input transfer.
    always @(posedge i_clk) begin : monitor
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                out_count++;
                if (audio_q.size() == 0) begin
                    note_error("audio with nothing pending", 0, o_audio_out);
                end else begin
                    want = audio_q.pop_front();
                    if (o_audio_out !== want)
                        note_error("audio_out", want, o_audio_out);
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                in_count++;
                audio_q.push_back(envelope_predict(i_in_re, i_in_im));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d audio values pending",
                     cycle_count, audio_q.size());
            $display("am_envelope_dc_block_unit: mismatch");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] re,
                               input logic signed [SAMPLE_W-1:0] im);
        t_iq_sample s;
        s.re = re;
        s.im = im;
        sample_q.push_back(s);
    endtask

    // Block until every queued sample has transferred and every audio value is back.
    task automatic wait_idle();
        while (sample_q.size() != 0 || i_in_valid || audio_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready; mirror into the shadow.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DC_ENABLE)
            dc_enable = value[0];
        else
            pole_coef = value[ALPHA_W-1:0];
    endtask

    // One I or Q component: full-scale corners, values near zero, or anything.
    function automatic logic signed [SAMPLE_W-1:0] rand_component();
        int v;
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(4))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return SAMPLE_W'(1);
                endcase
            end
            1: begin
                v = $urandom_range(511);
                return SAMPLE_W'(v - 256);
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned ph;
        int unsigned ch;
        int unsigned k;
        logic [ALPHA_W-1:0] alpha_pick;

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings (filtered, alpha near one), corners of I and Q.
        in_idle_pct   = 13;
        out_stall_pct = 81;
        push_sample('0, '0);
        push_sample(S_MAX, '0);
        push_sample(S_MIN, '0);
        push_sample('0, S_MIN);
        push_sample(S_MIN, S_MIN);
        push_sample(S_MAX, S_MAX);
        push_sample('1, '1);
        push_sample(SAMPLE_W'(3), SAMPLE_W'(-4));
        push_sample(S_MIN, S_MAX);
        push_sample('0, '0);
        wait_idle();

        // Plain mode: half magnitude, accumulator frozen.
        reg_write(REG_DC_ENABLE, 32'd0);
        push_sample(S_MIN, S_MIN);
        push_sample(S_MAX, '0);
        push_sample(SAMPLE_W'(1), '0);
        push_sample(SAMPLE_W'(-5), SAMPLE_W'(12));
        push_sample('0, '0);
        wait_idle();

        // Build up the accumulator with alpha at full scale, then drop alpha to
        // zero so the step down drives the audio into negative saturation.
        reg_write(REG_DC_ENABLE, 32'd1);
        reg_write(REG_POLE_COEF, 32'(16'hFFFF));
        repeat (3) push_sample(S_MIN, S_MIN);
        wait_idle();
        reg_write(REG_POLE_COEF, 32'd0);
        push_sample('0, '0);
        push_sample('0, '0);
        push_sample(S_MAX, S_MIN);
        wait_idle();

        // Random phases: sender idles lightly / receiver heavily, then the reverse,
        // then neither. Retune the registers between chunks, extremes included.
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct   = 13;
                    out_stall_pct = 81;
                end
                1: begin
                    in_idle_pct   = 81;
                    out_stall_pct = 13;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            for (ch = 0; ch < PHASE_SAMPLES / CHUNK_SAMPLES; ch++) begin
                wait_idle();
                case ($urandom_range(4))
                    0:       alpha_pick = '0;
                    1:       alpha_pick = '1;
                    2:       alpha_pick = ALPHA_RESET;
                    default: alpha_pick = ALPHA_W'($urandom_range(65535));
                endcase
                reg_write(REG_DC_ENABLE, 32'($urandom_range(3) != 0));
                reg_write(REG_POLE_COEF, 32'(alpha_pick));
                for (k = 0; k < CHUNK_SAMPLES; k++) begin
                    if ($urandom_range(9) == 0)
                        push_sample('0, '0);
                    else
                        push_sample(rand_component(), rand_component());
                end
            end
        end

        // Drain, then give a late or extra audio transfer time to show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (audio_q.size() != 0)
            note_error("audio values never delivered", audio_q.size(), 0);

        $display("%0d IQ samples sent, %0d audio transfers checked, %0d errors",
                 in_count, out_count, err_count);
        $display("plain and filtered modes, alpha extremes, accumulator clamped %0d times",
                 clamp_count);
        if (err_count == 0) begin
            $display("am_envelope_dc_block_unit: match");
        end else begin
            $display("am_envelope_dc_block_unit: mismatch");
        end
        $finish;
    end

endmodule
